/* rtl/wcf_pkg.sv */
`default_nettype none

package wcf_pkg;

    localparam int PIX_W      = 8;
    localparam int MODE_W     = 3;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] MODE_BOX     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SHARPEN = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SOBEL_X = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SOBEL_Y = 3'd4;

    localparam logic [MODE_W-1:0] RST_MODE   = MODE_BOX;
    localparam logic [FW_W-1:0]   RST_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0]   RST_HEIGHT = 12'd480;

    localparam int Q_DEPTH = 8;
    localparam int Q_IDX_W = 3;
    localparam int Q_CNT_W = 4;

    localparam int GAUSS_W     = 12;
    localparam int GAUSS_SHIFT = 4;
    localparam int SOBEL_W     = 10;
    localparam int DIV3_MUL    = 1366;
    localparam int DIV3_SHIFT  = 12;
    localparam int BOX_SHIFT   = 20;

    typedef logic [PIX_W-1:0] t_pix;

    localparam t_pix PIX_MAX = 8'hFF;

    typedef struct packed {
        logic emit;
        logic last;
    } t_tag;

endpackage

`default_nettype wire

/* rtl/wcf_ram.sv */
`default_nettype none

module wcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* rtl/wcf_window.sv */
`default_nettype none

module wcf_window import wcf_pkg::*; #(
    parameter int MAX_LINE = 1024,
    parameter int WINDOW = 3,
    localparam int ADDR_W = $clog2(MAX_LINE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_valid,
    input  logic              i_fwd,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_pix              i_px,
    input  t_tag              i_tag,
    output logic              o_valid,
    output logic              o_last,
    output t_pix              o_win [WINDOW][WINDOW]
);

    t_pix rd_data [WINDOW-1];
    t_pix n_col [WINDOW];
    t_pix r_last_col [WINDOW-1];
    t_pix r_win [WINDOW][WINDOW];
    logic r_valid;
    logic r_last;

    for (genvar k = 0; k < WINDOW - 1; k++) begin : g_line
        wcf_ram #(
            .WIDTH(PIX_W),
            .DEPTH(MAX_LINE)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_valid),
            .i_wr_addr (i_addr),
            .i_wr_data (n_col[k+1]),
            .i_rd_en   (i_rd_en),
            .i_rd_addr (i_rd_addr),
            .o_rd_data (rd_data[k])
        );
    end

    // take the column just written when the same entry is read back at once
    always_comb begin
        for (int k = 0; k < WINDOW - 1; k++) begin
            n_col[k] = i_fwd ? r_last_col[k] : rd_data[k];
        end
        n_col[WINDOW-1] = i_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int i = 0; i < WINDOW; i++) begin
                for (int j = 0; j < WINDOW; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_valid <= i_valid && i_tag.emit;
            if (i_valid) begin
                for (int i = 0; i < WINDOW; i++) begin
                    for (int j = 0; j < WINDOW - 1; j++) begin
                        r_win[i][j] <= r_win[i][j+1];
                    end
                    r_win[i][WINDOW-1] <= n_col[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_last <= i_tag.last;
            for (int k = 0; k < WINDOW - 1; k++) begin
                r_last_col[k] <= n_col[k+1];
            end
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_win   = r_win;

endmodule

`default_nettype wire

/* rtl/wcf_kernel.sv */
`default_nettype none

module wcf_kernel import wcf_pkg::*; #(
    parameter int WINDOW = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_valid,
    input  logic              i_last,
    input  t_pix              i_win [WINDOW][WINDOW],
    output logic              o_valid,
    output logic              o_last,
    output t_pix              o_pixel
);

    localparam int KER        = 3;
    localparam int CB         = WINDOW / 2 - 1;
    localparam int TAPS       = WINDOW * WINDOW;
    localparam int SUM_W      = $clog2(TAPS * 255 + 1);
    localparam int RAW_W      = ((SUM_W > GAUSS_W) ? SUM_W : GAUSS_W) + 1;
    localparam int BOX_MUL    = ((1 << BOX_SHIFT) + TAPS - 1) / TAPS;
    localparam int BOX_MUL_W  = $clog2(BOX_MUL + 1);
    localparam int BOX_PROD_W = SUM_W + BOX_MUL_W;
    localparam int DIV3_W     = $clog2(DIV3_MUL + 1);
    localparam int SOB_PROD_W = SOBEL_W + DIV3_W;
    localparam int SOB_Q_W    = SOB_PROD_W - DIV3_SHIFT;

    t_pix                    tp [KER][KER];
    logic [SUM_W-1:0]        box_sum;
    logic [GAUSS_W-1:0]      sum9;
    logic [GAUSS_W-1:0]      gauss_sum;
    logic [RAW_W-1:0]        ten_c;
    logic [SOBEL_W-1:0]      sob_pos;
    logic [SOBEL_W-1:0]      sob_neg;
    logic [SOBEL_W-1:0]      sob_abs;
    logic signed [RAW_W-1:0] n_raw;

    logic                    r_c_valid;
    logic                    r_c_last;
    logic [MODE_W-1:0]       r_c_mode;
    logic signed [RAW_W-1:0] r_c_raw;

    logic [BOX_PROD_W-1:0]   box_prod;
    logic [SOB_PROD_W-1:0]   sob_prod;
    logic [SOB_Q_W-1:0]      sob_q;
    t_pix                    n_pixel;

    logic                    r_d_valid;
    logic                    r_d_last;
    t_pix                    r_d_pixel;

    always_comb begin
        for (int i = 0; i < KER; i++) begin
            for (int j = 0; j < KER; j++) begin
                tp[i][j] = i_win[CB+i][CB+j];
            end
        end

        box_sum = '0;
        for (int i = 0; i < WINDOW; i++) begin
            for (int j = 0; j < WINDOW; j++) begin
                box_sum = box_sum + SUM_W'(i_win[i][j]);
            end
        end

        sum9 = '0;
        for (int i = 0; i < KER; i++) begin
            for (int j = 0; j < KER; j++) begin
                sum9 = sum9 + GAUSS_W'(tp[i][j]);
            end
        end

        gauss_sum = GAUSS_W'(tp[0][0]) + GAUSS_W'({tp[0][1], 1'b0}) + GAUSS_W'(tp[0][2])
                  + GAUSS_W'({tp[1][0], 1'b0}) + GAUSS_W'({tp[1][1], 2'b00})
                  + GAUSS_W'({tp[1][2], 1'b0})
                  + GAUSS_W'(tp[2][0]) + GAUSS_W'({tp[2][1], 1'b0}) + GAUSS_W'(tp[2][2]);

        ten_c = RAW_W'({tp[1][1], 3'b000}) + RAW_W'({tp[1][1], 1'b0});

        if (i_mode == MODE_SOBEL_Y) begin
            sob_pos = SOBEL_W'(tp[2][0]) + SOBEL_W'({tp[2][1], 1'b0}) + SOBEL_W'(tp[2][2]);
            sob_neg = SOBEL_W'(tp[0][0]) + SOBEL_W'({tp[0][1], 1'b0}) + SOBEL_W'(tp[0][2]);
        end else begin
            sob_pos = SOBEL_W'(tp[0][2]) + SOBEL_W'({tp[1][2], 1'b0}) + SOBEL_W'(tp[2][2]);
            sob_neg = SOBEL_W'(tp[0][0]) + SOBEL_W'({tp[1][0], 1'b0}) + SOBEL_W'(tp[2][0]);
        end
        sob_abs = (sob_pos >= sob_neg) ? (sob_pos - sob_neg) : (sob_neg - sob_pos);

        case (i_mode) inside
            MODE_GAUSS: begin
                n_raw = $signed(RAW_W'(gauss_sum));
            end
            MODE_SHARPEN: begin
                n_raw = $signed(ten_c - RAW_W'(sum9));
            end
            MODE_SOBEL_X, MODE_SOBEL_Y: begin
                n_raw = $signed(RAW_W'(sob_abs));
            end
            default: begin
                n_raw = $signed(RAW_W'(box_sum));
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_c_last <= i_last;
            r_c_mode <= i_mode;
            r_c_raw  <= n_raw;
        end
    end

    // divide by constants through reciprocal multiplies or a shift, and saturate sharpen and Sobel results
    always_comb begin
        box_prod = BOX_PROD_W'(r_c_raw[SUM_W-1:0]) * BOX_PROD_W'(BOX_MUL);
        sob_prod = SOB_PROD_W'(r_c_raw[SOBEL_W-1:0]) * SOB_PROD_W'(DIV3_MUL);
        sob_q    = sob_prod[SOB_PROD_W-1:DIV3_SHIFT];

        case (r_c_mode) inside
            MODE_GAUSS: begin
                n_pixel = r_c_raw[GAUSS_SHIFT+PIX_W-1:GAUSS_SHIFT];
            end
            MODE_SHARPEN: begin
                if (r_c_raw < $signed(RAW_W'(0))) begin
                    n_pixel = '0;
                end else if (r_c_raw > $signed(RAW_W'(PIX_MAX))) begin
                    n_pixel = PIX_MAX;
                end else begin
                    n_pixel = r_c_raw[PIX_W-1:0];
                end
            end
            MODE_SOBEL_X, MODE_SOBEL_Y: begin
                n_pixel = (sob_q > SOB_Q_W'(PIX_MAX)) ? PIX_MAX : sob_q[PIX_W-1:0];
            end
            default: begin
                n_pixel = box_prod[BOX_SHIFT+PIX_W-1:BOX_SHIFT];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_d_last  <= r_c_last;
            r_d_pixel <= n_pixel;
        end
    end

    assign o_valid = r_d_valid;
    assign o_last  = r_d_last;
    assign o_pixel = r_d_pixel;

endmodule

`default_nettype wire

/* rtl/wcf_outq.sv */
`default_nettype none

module wcf_outq import wcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pix i_pixel,
    input  logic i_last,
    output logic o_valid,
    input  logic i_stall,
    output t_pix o_pixel,
    output logic o_last,
    output logic o_pop
);

    t_pix               r_pix [Q_DEPTH];
    logic               r_last [Q_DEPTH];
    logic [Q_IDX_W-1:0] r_wr_ptr;
    logic [Q_IDX_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_CNT_W-1:0] n_cnt;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && !i_stall;
    assign n_cnt   = r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_IDX_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pix[r_wr_ptr]  <= i_pixel;
            r_last[r_wr_ptr] <= i_last;
        end
    end

    assign o_pixel = r_pix[r_rd_ptr];
    assign o_last  = r_last[r_rd_ptr];
    assign o_pop   = pop;

endmodule

`default_nettype wire

/* rtl/window_convolution_filter.sv */
// Channel  Dir  Handshake                  Payload
// config   in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// pixel    in   i_in_valid / o_in_stall    i_pixel_in
// result   out  o_out_valid / i_out_stall  o_pixel_out, o_frame_done
//
// One pixel per clock while o_in_stall is low.
// A pixel passes the input capture, window update, filter sum, divide and result queue stages in order.
// o_in_stall rises while 8 results sit in the result queue or in flight.
// Reset clears window, counters and queue, and loads mode 0 at 640 x 480; line stores keep data.
`default_nettype none

module window_convolution_filter import wcf_pkg::*; #(
    parameter int MAX_LINE = 1024,
    parameter int WINDOW = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic                  o_frame_done
);

    localparam int COL_W = $clog2(MAX_LINE);
    localparam int LIM_W = ($clog2(MAX_LINE + 1) > FW_W) ? $clog2(MAX_LINE + 1) : FW_W;

    logic [MODE_W-1:0]  r_mode;
    logic [FW_W-1:0]    r_width;
    logic [FH_W-1:0]    r_height;
    logic [COL_W-1:0]   r_col;
    logic [FH_W-1:0]    r_row;
    logic [Q_CNT_W-1:0] r_credit;

    logic               r_a_valid;
    logic               r_a_fwd;
    t_pix               r_a_px;
    logic [COL_W-1:0]   r_a_addr;
    t_tag               r_a_tag;

    logic               cfg_we;
    logic               accept;
    logic [LIM_W-1:0]   w_eff;
    logic [LIM_W-1:0]   c_ext;
    logic [FH_W-1:0]    h_eff;
    logic               restart;
    logic [COL_W-1:0]   c_col;
    logic [FH_W-1:0]    c_row;
    logic               emit;
    logic               last;
    logic               wrap;
    logic [COL_W-1:0]   n_col;
    logic [FH_W-1:0]    n_row;
    t_tag               tag;

    logic               win_valid;
    logic               win_last;
    t_pix               win [WINDOW][WINDOW];
    logic               res_valid;
    logic               res_last;
    t_pix               res_pixel;
    logic               pop;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RST_MODE;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_WIDTH:  r_width  <= i_cfg_data[FW_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_credit >= Q_CNT_W'(Q_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        w_eff = LIM_W'(r_width);
        if (r_width == '0) begin
            w_eff = LIM_W'(1);
        end else if (LIM_W'(r_width) > LIM_W'(MAX_LINE)) begin
            w_eff = LIM_W'(MAX_LINE);
        end
        h_eff = (r_height == '0) ? FH_W'(1) : r_height;

        // restart the frame when a counter lies beyond a new size
        restart = (LIM_W'(r_col) >= w_eff) || (r_row >= h_eff);
        c_col   = restart ? '0 : r_col;
        c_row   = restart ? '0 : r_row;
        c_ext   = LIM_W'(c_col);

        emit = (c_row >= FH_W'(WINDOW - 1)) && (c_ext >= LIM_W'(WINDOW - 1));
        last = (c_ext == w_eff - LIM_W'(1)) && (c_row == h_eff - FH_W'(1));
        wrap = (c_ext + LIM_W'(1)) >= w_eff;

        if (wrap) begin
            n_col = '0;
            n_row = ((c_row + FH_W'(1)) >= h_eff) ? '0 : c_row + FH_W'(1);
        end else begin
            n_col = c_col + COL_W'(1);
            n_row = c_row;
        end

        tag.emit = emit;
        tag.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_credit  <= '0;
        end else begin
            r_a_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_credit <= r_credit + Q_CNT_W'(accept && emit) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_px   <= i_pixel_in;
            r_a_addr <= c_col;
            r_a_tag  <= tag;
            r_a_fwd  <= r_a_valid && (c_col == r_a_addr);
        end
    end

    wcf_window #(
        .MAX_LINE(MAX_LINE),
        .WINDOW(WINDOW)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (c_col),
        .i_valid   (r_a_valid),
        .i_fwd     (r_a_fwd),
        .i_addr    (r_a_addr),
        .i_px      (r_a_px),
        .i_tag     (r_a_tag),
        .o_valid   (win_valid),
        .o_last    (win_last),
        .o_win     (win)
    );

    wcf_kernel #(
        .WINDOW(WINDOW)
    ) u_kernel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (win_valid),
        .i_last  (win_last),
        .i_win   (win),
        .o_valid (res_valid),
        .o_last  (res_last),
        .o_pixel (res_pixel)
    );

    wcf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_pixel (res_pixel),
        .i_last  (res_last),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_pixel (o_pixel_out),
        .o_last  (o_frame_done),
        .o_pop   (pop)
    );

endmodule

`default_nettype wire

/* rtl/wcf_chk.sv */
`default_nettype none

module wcf_chk import wcf_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [PIX_W-1:0] o_pixel_out,
    input logic             o_frame_done
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pixel_out) && $stable(o_frame_done))
        else $error("result payload changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result request right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 5))
        else $error("result appeared without a pixel request five clocks earlier");

endmodule

bind window_convolution_filter wcf_chk u_chk (.*);

`default_nettype wire
